// ===== sv/vntp_pkg.sv =====
// vntp_pkg: shared constants, register codes and the sine table function
// for the value-noise texture pixel block
// no dependencies
package vntp_pkg;

    localparam int COORD_W = 48;
    localparam int NOISE_W = 24;
    localparam int CFG_W   = 48;
    localparam int CFG_IDX_W = 3;

    localparam int DEFAULT_MAX_EDGE  = 4096;
    localparam int DEFAULT_SINE_DEPTH = 1024;

    // hash multipliers
    localparam logic [31:0] HASH_KX = 32'd374761393;
    localparam logic [31:0] HASH_KY = 32'd668265263;
    localparam logic [31:0] HASH_KS = 32'd362437;
    localparam logic [31:0] HASH_KM = 32'd1274126177;

    // octave seed offsets
    localparam logic [31:0] SEED_MID   = 32'd17;
    localparam logic [31:0] SEED_HI    = 32'd53;
    localparam logic [31:0] SEED_GRAIN = 32'd97;
    localparam logic [31:0] SEED_RIDGE = 32'd131;

    // reset values
    localparam logic [23:0] COORD_SCALE_RST   = 24'd3277;
    localparam logic [15:0] CONTRAST_GAIN_RST = 16'd4096;
    localparam logic [12:0] TEXTURE_SIZE_RST  = 13'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COORD_SCALE   = 3'd0,
        REG_NOISE_SEED    = 3'd1,
        REG_BASE_COLOR    = 3'd2,
        REG_TINT_COLOR    = 3'd3,
        REG_CONTRAST_GAIN = 3'd4,
        REG_GRAIN_BLEND   = 3'd5,
        REG_TEXTURE_SIZE  = 3'd6
    } cfg_reg_t;

    // sin of one table angle, q1.15, from the angle as a 32 bit turn fraction
    function automatic logic signed [16:0] sine_from_turn(input logic [31:0] turn);
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        quad = turn[31:30];
        r    = {34'd0, turn[29:0]};
        q    = quad[0] ? (64'h40000000 - r) : r;
        x    = (q * 64'd1686629713) >> 30;
        x2   = (x * x) >> 30;
        t    = 64'h40000000 - x2 / 64'd72;
        t    = 64'h40000000 - ((x2 * t) >> 30) / 64'd42;
        t    = 64'h40000000 - ((x2 * t) >> 30) / 64'd20;
        t    = 64'h40000000 - ((x2 * t) >> 30) / 64'd6;
        s    = (((x * t) >> 30) + 64'd16384) >> 15;
        return quad[1] ? -$signed(17'(s)) : $signed(17'(s));
    endfunction

endpackage

// ===== sv/vntp_octave.sv =====
// vntp_octave: one value-noise lookup, four register stages
// (corner hash products, hash mix and smoothstep, x blend, y blend)
// depends on vntp_pkg
module vntp_octave
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [vntp_pkg::COORD_W-1:0]  coord_x,
    input  logic [vntp_pkg::COORD_W-1:0]  coord_y,
    input  logic [31:0]                   seed,
    output logic [vntp_pkg::NOISE_W-1:0]  noise
);
    import vntp_pkg::*;

    function automatic logic [23:0] mix24(input logic [23:0] a, input logic [23:0] b,
                                          input logic [24:0] s);
        logic [49:0] acc;
        acc = 50'(a) * 50'(25'h1000000 - s) + 50'(b) * 50'(s);
        return acc[47:24];
    endfunction

    logic [31:0] x0;
    logic [31:0] y0;

    // stage a
    logic [31:0] hx_reg [2];
    logic [31:0] hy_reg [2];
    logic [31:0] hs_reg;
    logic [15:0] tx_reg;
    logic [15:0] ty_reg;
    logic [31:0] tx2_reg;
    logic [31:0] ty2_reg;

    // stage b
    logic [31:0] hm_reg [4];
    logic [24:0] sx_reg;
    logic [24:0] sy_reg;

    // stage c
    logic [23:0] top_reg;
    logic [23:0] bot_reg;
    logic [24:0] syc_reg;

    // stage d
    logic [23:0] noise_reg;

    logic [31:0] hm_next [4];
    logic [23:0] corner [4];

    assign x0 = coord_x[47:16];
    assign y0 = coord_y[47:16];

    always_comb
    begin
        logic [31:0] h;
        for (int k = 0; k < 4; k++)
        begin
            h = (hx_reg[k % 2] + hy_reg[k / 2]) ^ hs_reg;
            h = h ^ (h >> 13);
            hm_next[k] = h * HASH_KM;
            corner[k] = hm_reg[k][23:0] ^ {8'd0, hm_reg[k][31:16]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx_reg[0] <= x0 * HASH_KX;
            hx_reg[1] <= (x0 + 32'd1) * HASH_KX;
            hy_reg[0] <= y0 * HASH_KY;
            hy_reg[1] <= (y0 + 32'd1) * HASH_KY;
            hs_reg    <= seed * HASH_KS;
            tx_reg    <= coord_x[15:0];
            ty_reg    <= coord_y[15:0];
            tx2_reg   <= 32'(coord_x[15:0]) * 32'(coord_x[15:0]);
            ty2_reg   <= 32'(coord_y[15:0]) * 32'(coord_y[15:0]);

            for (int k = 0; k < 4; k++)
            begin
                hm_reg[k] <= hm_next[k];
            end
            sx_reg <= 25'((50'(tx2_reg) * (50'd196608 - 50'(tx_reg) * 50'd2)) >> 24);
            sy_reg <= 25'((50'(ty2_reg) * (50'd196608 - 50'(ty_reg) * 50'd2)) >> 24);

            top_reg <= mix24(corner[0], corner[1], sx_reg);
            bot_reg <= mix24(corner[2], corner[3], sx_reg);
            syc_reg <= sy_reg;

            noise_reg <= mix24(top_reg, bot_reg, syc_reg);
        end
    end

    assign noise = noise_reg;

endmodule

// ===== sv/value_noise_texture_pixel.sv =====
// value_noise_texture_pixel: procedural stone texture, one pixel per transaction
// top level: config registers, coordinate and combine pipeline, sine table
// depends on vntp_pkg and vntp_octave
//
// Takes one pixel (x, y) per clock while the output side keeps taking
// results. Its 8 bit rgb and linear index leave from the output register
// at the end of the stage chain, and new pixels enter while earlier ones
// are still in it. That rate holds as every stage is a register stage
// fed by one multiply level, the five noise octaves run side by side in their
// own four stage lookups, and the sine strata table is a registered constant
// rom read once per pixel. A stall on the output side freezes the whole chain
// at once, so nothing is lost or repeated; s_tready is low only while a
// finished result sits in the output register and m_tready is low.
// Configuration writes take effect on the next clock and are meant for idle
// periods only.
module value_noise_texture_pixel
#(
    parameter int MAX_EDGE         = vntp_pkg::DEFAULT_MAX_EDGE,
    parameter int SINE_TABLE_DEPTH = vntp_pkg::DEFAULT_SINE_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // config write port
    input  logic                            cfg_wen,
    input  logic [vntp_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [vntp_pkg::CFG_W-1:0]      cfg_wdata,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // pixel_x[11:0], pixel_y[23:12]
    // pixel result
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata    // red, green, blue, pixel_index[47:24]
);
    import vntp_pkg::*;

    localparam int EDGE_W = $clog2(MAX_EDGE + 1);
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int PPROD_W = 48 + IDX_W + 1;
    localparam int NSTAGE = 15;

    // ---------------- config registers ----------------
    logic [23:0] coord_scale_reg;
    logic [31:0] noise_seed_reg;
    logic [47:0] base_color_reg;
    logic [47:0] tint_color_reg;
    logic [15:0] contrast_gain_reg;
    logic [15:0] grain_blend_reg;
    logic [12:0] texture_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_scale_reg   <= COORD_SCALE_RST;
            noise_seed_reg    <= '0;
            base_color_reg    <= '0;
            tint_color_reg    <= '0;
            contrast_gain_reg <= CONTRAST_GAIN_RST;
            grain_blend_reg   <= '0;
            texture_size_reg  <= TEXTURE_SIZE_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_COORD_SCALE:   coord_scale_reg   <= cfg_wdata[23:0];
                REG_NOISE_SEED:    noise_seed_reg    <= cfg_wdata[31:0];
                REG_BASE_COLOR:    base_color_reg    <= cfg_wdata[47:0];
                REG_TINT_COLOR:    tint_color_reg    <= cfg_wdata[47:0];
                REG_CONTRAST_GAIN: contrast_gain_reg <= cfg_wdata[15:0];
                REG_GRAIN_BLEND:   grain_blend_reg   <= cfg_wdata[15:0];
                REG_TEXTURE_SIZE:  texture_size_reg  <= cfg_wdata[12:0];
                default:           ; // unknown index, write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // one enable for every stage, valid bits ride along
    logic              adv;
    logic [NSTAGE:1]   valid_reg;

    assign adv      = !valid_reg[NSTAGE] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[NSTAGE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NSTAGE-1:1], s_tvalid};
        end
    end

    // ---------------- stage 1: noise coordinates and index ----------------
    logic [11:0]        px;
    logic [11:0]        py;
    logic [EDGE_W-1:0]  edge_len;
    logic [35:0]        fx_reg;
    logic [35:0]        fy_reg;
    logic [23:0]        index_pipe_reg [1:NSTAGE];

    assign px = s_tdata[11:0];
    assign py = s_tdata[23:12];
    // texture edge above the limit is used as the limit
    assign edge_len = (EDGE_W'(texture_size_reg) > EDGE_W'(MAX_EDGE) ||
                       texture_size_reg > 13'(MAX_EDGE))
                      ? EDGE_W'(MAX_EDGE) : EDGE_W'(texture_size_reg);

    // ---------------- stage 2: octave scales and phase products ----------------
    logic [35:0] fx2_reg;
    logic [35:0] fy2_reg;
    logic [39:0] c10x_reg;
    logic [39:0] c10y_reg;
    logic [53:0] p34x_reg;
    logic [53:0] p34y_reg;
    logic [39:0] pa_reg;
    logic [39:0] pb_reg;

    // ---------------- stages 3..6: octave lookups ----------------
    logic [COORD_W-1:0] oct_x [5];
    logic [COORD_W-1:0] oct_y [5];
    logic [31:0]        oct_seed [5];
    logic [NOISE_W-1:0] oct_val [5];
    logic [39:0]        base_pipe_reg [3:6];

    assign oct_x[0] = COORD_W'(fx2_reg);
    assign oct_y[0] = COORD_W'(fy2_reg);
    assign oct_x[1] = COORD_W'({fx2_reg, 1'b0});
    assign oct_y[1] = COORD_W'({fy2_reg, 1'b0});
    assign oct_x[2] = COORD_W'({fx2_reg, 2'b0});
    assign oct_y[2] = COORD_W'({fy2_reg, 2'b0});
    assign oct_x[3] = COORD_W'(c10x_reg);
    assign oct_y[3] = COORD_W'(c10y_reg);
    // scale 3.4, rounded half up
    assign oct_x[4] = COORD_W'((p34x_reg + 54'd32768) >> 16);
    assign oct_y[4] = COORD_W'((p34y_reg + 54'd32768) >> 16);

    assign oct_seed[0] = noise_seed_reg;
    assign oct_seed[1] = noise_seed_reg + SEED_MID;
    assign oct_seed[2] = noise_seed_reg + SEED_HI;
    assign oct_seed[3] = noise_seed_reg + SEED_GRAIN;
    assign oct_seed[4] = noise_seed_reg + SEED_RIDGE;

    for (genvar go = 0; go < 5; go++)
    begin : g_octave
        vntp_octave u_octave
        (
            .clk     (clk),
            .en      (adv),
            .coord_x (oct_x[go]),
            .coord_y (oct_y[go]),
            .seed    (oct_seed[go]),
            .noise   (oct_val[go])
        );
    end

    // ---------------- stage 7: ridge and strata phase ----------------
    logic [23:0] low_reg  [7:9];
    logic [23:0] mid_reg  [7:9];
    logic [23:0] hi_reg   [7:9];
    logic [23:0] grain_reg [7:10];
    logic [24:0] ridge_reg [7:9];
    logic [47:0] phase_reg;

    logic [24:0] ridge_next;
    logic [47:0] phase_next;

    always_comb
    begin
        logic signed [24:0] mid_d;
        logic signed [49:0] mid_p;
        logic [23:0]        rv;
        rv = oct_val[4];
        // ridge folds the value around one half
        if (rv[23])
        begin
            ridge_next = 25'h1000000 - ({rv, 1'b0} - 25'h1000000);
        end
        else
        begin
            ridge_next = 25'h1000000 - (25'h1000000 - {rv, 1'b0});
        end
        mid_d = $signed({1'b0, oct_val[1]}) - 25'sd8388608;
        mid_p = 50'(mid_d) * 50'sd9612637;
        phase_next = {base_pipe_reg[6], 8'd0} + 48'(mid_p);
    end

    // ---------------- stage 8: table index and highlight ----------------
    logic [IDX_W-1:0] tidx_reg;
    logic [24:0]      hl_pipe_reg [8:13];

    logic [PPROD_W-1:0] idx_prod;
    logic [24:0]        hl_next;

    always_comb
    begin
        logic signed [24:0] hd;
        logic signed [24:0] gd;
        logic signed [41:0] hl;
        idx_prod = PPROD_W'(phase_reg) * PPROD_W'(SINE_TABLE_DEPTH);
        hd = $signed({1'b0, hi_reg[7]}) - 25'sd8388608;
        gd = $signed({1'b0, grain_reg[7]}) - 25'sd8388608;
        hl = 42'sd989560438784 + 42'(hd) * 42'sd14418 + 42'(gd) * 42'sd6554
             + 42'sd32768;
        hl_next = hl[40:16];
    end

    // ---------------- stage 9: sine table ----------------
    logic signed [16:0] sine_rom [SINE_TABLE_DEPTH];
    logic signed [16:0] sine_reg;

    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++)
    begin : g_sine
        localparam logic [63:0] TURN = (64'(gi) << 32) / SINE_TABLE_DEPTH;
        assign sine_rom[gi] = sine_from_turn(TURN[31:0]);
    end

    // ---------------- stage 10: weighted octave sum ----------------
    logic [25:0] nsum_reg;
    logic [25:0] nsum_next;

    always_comb
    begin
        logic signed [25:0] strata_s;
        logic [24:0]        strata;
        logic [41:0]        acc;
        strata_s = 26'sd8388608 + 26'(sine_reg) * 26'sd256;
        strata   = strata_s[24:0];
        acc = 42'(low_reg[9]) * 42'd27525 + 42'(mid_reg[9]) * 42'd15729
              + 42'(hi_reg[9]) * 42'd8520 + 42'(ridge_reg[9]) * 42'd8520
              + 42'(strata) * 42'd5243 + 42'd32768;
        nsum_next = acc[41:16];
    end

    // ---------------- stage 11: grain mix ----------------
    logic [25:0] ngrain_reg;
    logic [25:0] ngrain_next;

    always_comb
    begin
        logic [42:0] acc;
        acc = 43'(nsum_reg) * 43'(17'h10000 - 17'(grain_blend_reg))
              + 43'(grain_reg[10]) * 43'(grain_blend_reg) + 43'd32768;
        ngrain_next = acc[41:16];
    end

    // ---------------- stage 12: contrast stretch and clamp ----------------
    logic [24:0] ncon_reg;
    logic [24:0] ncon_next;

    always_comb
    begin
        logic signed [26:0] diff;
        logic signed [45:0] cval;
        diff = $signed({1'b0, ngrain_reg}) - 27'sd8388608;
        cval = 46'(diff) * 46'($signed({1'b0, contrast_gain_reg})) + 46'sd34359740416;
        if (cval[45])
        begin
            ncon_next = '0;
        end
        else if (cval[44:12] > 33'h1000000)
        begin
            ncon_next = 25'h1000000;
        end
        else
        begin
            ncon_next = cval[36:12];
        end
    end

    // ---------------- stages 13..15: colour shading ----------------
    logic [15:0] blend_reg [3];
    logic [15:0] shade_reg [3];
    logic [7:0]  byte_reg  [3];

    logic [15:0] blend_next [3];
    logic [15:0] shade_next [3];
    logic [7:0]  byte_next  [3];

    always_comb
    begin
        logic [41:0] acc_b;
        logic [41:0] acc_s;
        logic [23:0] acc_o;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc_b = 42'(base_color_reg[(2 - ch) * 16 +: 16]) * 42'(25'h1000000 - ncon_reg)
                    + 42'(tint_color_reg[(2 - ch) * 16 +: 16]) * 42'(ncon_reg)
                    + 42'h800000;
            blend_next[ch] = acc_b[39:24];
            acc_s = 42'(blend_reg[ch]) * 42'(hl_pipe_reg[13]) + 42'h800000;
            // components above one are clamped after shading
            shade_next[ch] = (acc_s[41:24] > 18'd32768) ? 16'd32768 : acc_s[39:24];
            acc_o = 24'(shade_reg[ch]) * 24'd255 + 24'd16384;
            byte_next[ch] = acc_o[22:15];
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            fx_reg <= 36'(px) * 36'(coord_scale_reg);
            fy_reg <= 36'(py) * 36'(coord_scale_reg);
            index_pipe_reg[1] <= 24'(24'(py) * 24'(edge_len) + 24'(px));
            for (int s = 2; s <= NSTAGE; s++)
            begin
                index_pipe_reg[s] <= index_pipe_reg[s-1];
            end

            // stage 2
            fx2_reg  <= fx_reg;
            fy2_reg  <= fy_reg;
            c10x_reg <= {fx_reg, 3'd0} + {2'd0, fx_reg, 1'b0};
            c10y_reg <= {fy_reg, 3'd0} + {2'd0, fy_reg, 1'b0};
            p34x_reg <= 54'(fx_reg) * 54'd222822;
            p34y_reg <= 54'(fy_reg) * 54'd222822;
            pa_reg   <= 40'(fx_reg) * 40'd7130317;
            pb_reg   <= 40'(fy_reg) * 40'd4613734;

            // phase base rides beside the octave lookups
            base_pipe_reg[3] <= pa_reg + pb_reg;
            for (int s = 4; s <= 6; s++)
            begin
                base_pipe_reg[s] <= base_pipe_reg[s-1];
            end

            // stage 7
            low_reg[7]   <= oct_val[0];
            mid_reg[7]   <= oct_val[1];
            hi_reg[7]    <= oct_val[2];
            grain_reg[7] <= oct_val[3];
            ridge_reg[7] <= ridge_next;
            phase_reg    <= phase_next;
            for (int s = 8; s <= 9; s++)
            begin
                low_reg[s]   <= low_reg[s-1];
                mid_reg[s]   <= mid_reg[s-1];
                hi_reg[s]    <= hi_reg[s-1];
                ridge_reg[s] <= ridge_reg[s-1];
            end
            for (int s = 8; s <= 10; s++)
            begin
                grain_reg[s] <= grain_reg[s-1];
            end

            // stage 8
            tidx_reg       <= idx_prod[48 +: IDX_W];
            hl_pipe_reg[8] <= hl_next;
            for (int s = 9; s <= 13; s++)
            begin
                hl_pipe_reg[s] <= hl_pipe_reg[s-1];
            end

            // stage 9
            sine_reg <= sine_rom[tidx_reg];

            // stages 10..12
            nsum_reg   <= nsum_next;
            ngrain_reg <= ngrain_next;
            ncon_reg   <= ncon_next;

            // stages 13..15
            for (int ch = 0; ch < 3; ch++)
            begin
                blend_reg[ch] <= blend_next[ch];
                shade_reg[ch] <= shade_next[ch];
                byte_reg[ch]  <= byte_next[ch];
            end
        end
    end

    assign m_tdata = {index_pipe_reg[NSTAGE], byte_reg[2], byte_reg[1], byte_reg[0]};

    // ---------------- assertions ----------------
    // a held result freezes every stage, occupancy included
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(valid_reg))
        else $error("pipeline moved during output stall");

    // contrast result never passes full scale
    a_contrast_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[12] |-> (ncon_reg <= 25'h1000000))
        else $error("contrast result above one");

    // shaded components are clamped to one before the byte stage
    a_shade_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[14] |-> (shade_reg[0] <= 16'd32768 && shade_reg[1] <= 16'd32768 &&
                           shade_reg[2] <= 16'd32768))
        else $error("shaded component above one");

endmodule
